>>> rtl/wsfr_pkg.sv
// wsfr_pkg: shared types, codes and constants for the WebSocket frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package wsfr_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_TX    = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_DISC  = 2'd3
  } kind_e;

  // Disconnect reasons
  typedef enum logic [1:0] {
    RSN_PEER  = 2'd0,
    RSN_PROTO = 2'd1,
    RSN_BIG   = 2'd2,
    RSN_UNSUP = 2'd3
  } reason_e;

  // Opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [3:0] HDR0_FIN_ONLY = 4'h8;   // FIN set, RSV clear
  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
  localparam logic [7:0] HDR_PONG      = 8'h8A;
  localparam logic [7:0] HDR_CLOSE     = 8'h88;

  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd204;

  // Result queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        frame_end;
    reason_e     reason;
    logic        run_last;
  } res_t;

  // Up to two results produced by one received byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t mk_res(input kind_e k, input logic [7:0] d,
                                  input logic [3:0] op, input logic fe,
                                  input reason_e rs);
    res_t r;
    r.kind      = k;
    r.data      = d;
    r.opcode    = op;
    r.frame_end = fe;
    r.reason    = rs;
    r.run_last  = 1'b0;
    return r;
  endfunction

  function automatic logic is_data_op(input logic [3:0] op);
    return (op == OP_TEXT) || (op == OP_BINARY);
  endfunction

endpackage

`default_nettype wire

>>> rtl/wsfr_decode.sv
// wsfr_decode: frame header parser, unmasking and reply generation.
// Holds the frame state; one byte per cycle while in_fire_i is high. Depends on wsfr_pkg.
`default_nettype none

module wsfr_decode #(
  parameter int LENGTH_BITS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_fire_i,
  input  wire  [7:0]            rx_byte_i,
  input  wire  [15:0]           max_payload_i,
  output wsfr_pkg::push_t       push_o
);
  import wsfr_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR0, PH_HDR1, PH_EXTHI, PH_EXTLO,
    PH_MASK0, PH_MASK1, PH_MASK2, PH_MASK3, PH_PAYLOAD
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [3:0]             op_q, op_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [7:0]             mask_q [4];
  logic [7:0]             mask_d [4];
  logic                   closed_q, closed_d;

  logic [LENGTH_BITS:0]   pos_p1;
  logic                   last;
  logic [15:0]            ext_v;
  logic [7:0]             pdata;
  logic [3:0]             hop;
  logic                   hop_ok;
  logic [6:0]             len7;
  logic [7:0]             close_len;
  res_t                   r0, r1;
  logic [1:0]             n;

  assign pos_p1 = {1'b0, pos_q} + {{LENGTH_BITS{1'b0}}, 1'b1};
  assign last   = pos_p1 >= {1'b0, len_q};
  assign ext_v  = {len_q[7:0], rx_byte_i};
  assign pdata  = rx_byte_i ^ mask_q[pos_q[1:0]];
  assign hop    = rx_byte_i[3:0];
  assign hop_ok = is_data_op(hop) || (hop == OP_CLOSE) || (hop == OP_PING) ||
                  (hop == OP_PONG);
  assign len7   = rx_byte_i[6:0];
  assign close_len = (len7 >= 7'd2) ? 8'd2 : 8'd0;

  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    len_d    = len_q;
    pos_d    = pos_q;
    mask_d   = mask_q;
    closed_d = closed_q;
    r0       = '0;
    r1       = '0;
    n        = 2'd0;

    if (!closed_q) begin
      unique case (phase_q)
        PH_HDR0: begin
          if (rx_byte_i[7:4] != HDR0_FIN_ONLY || !hop_ok) begin
            r0 = mk_res(KIND_DISC, 8'd0, 4'd0, 1'b0, RSN_UNSUP);
            n = 2'd1;
            closed_d = 1'b1;
          end else begin
            op_d    = hop;
            phase_d = PH_HDR1;
          end
        end
        PH_HDR1: begin
          if (!rx_byte_i[7]) begin
            r0 = mk_res(KIND_DISC, 8'd0, 4'd0, 1'b0, RSN_PROTO);
            n = 2'd1;
            closed_d = 1'b1;
            phase_d = PH_HDR0;
          end else if (len7 > LEN_EXT16) begin
            r0 = mk_res(KIND_DISC, 8'd0, 4'd0, 1'b0, RSN_BIG);
            n = 2'd1;
            closed_d = 1'b1;
            phase_d = PH_HDR0;
          end else if (len7 == LEN_EXT16) begin
            if (op_q[3]) begin
              // extended length on a control frame
              r0 = mk_res(KIND_DISC, 8'd0, 4'd0, 1'b0, RSN_PROTO);
              n = 2'd1;
              closed_d = 1'b1;
              phase_d = PH_HDR0;
            end else begin
              phase_d = PH_EXTHI;
            end
          end else begin
            len_d   = {{(LENGTH_BITS-7){1'b0}}, len7};
            mask_d  = '{default: 8'd0};
            phase_d = PH_MASK0;
            if (op_q == OP_PING) begin
              r0 = mk_res(KIND_TX, HDR_PONG, 4'd0, 1'b0, RSN_PEER);
              r1 = mk_res(KIND_TX, {1'b0, len7}, 4'd0, len7 == 7'd0, RSN_PEER);
              n = 2'd2;
            end else if (op_q == OP_CLOSE) begin
              r0 = mk_res(KIND_TX, HDR_CLOSE, 4'd0, 1'b0, RSN_PEER);
              r1 = mk_res(KIND_TX, close_len, 4'd0, close_len == 8'd0, RSN_PEER);
              n = 2'd2;
            end
          end
        end
        PH_EXTHI: begin
          len_d   = {{(LENGTH_BITS-8){1'b0}}, rx_byte_i};
          phase_d = PH_EXTLO;
        end
        PH_EXTLO: begin
          if (ext_v > max_payload_i || (ext_v >> LENGTH_BITS) != 16'd0) begin
            r0 = mk_res(KIND_DISC, 8'd0, 4'd0, 1'b0, RSN_BIG);
            n = 2'd1;
            closed_d = 1'b1;
            phase_d = PH_HDR0;
          end else begin
            len_d   = ext_v[LENGTH_BITS-1:0];
            mask_d  = '{default: 8'd0};
            phase_d = PH_MASK0;
          end
        end
        PH_MASK0: begin
          mask_d[0] = rx_byte_i;
          phase_d   = PH_MASK1;
        end
        PH_MASK1: begin
          mask_d[1] = rx_byte_i;
          phase_d   = PH_MASK2;
        end
        PH_MASK2: begin
          mask_d[2] = rx_byte_i;
          phase_d   = PH_MASK3;
        end
        PH_MASK3: begin
          mask_d[3] = rx_byte_i;
          if (len_q != '0) begin
            pos_d   = '0;
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_HDR0;
            if (is_data_op(op_q)) begin
              r0 = mk_res(KIND_EMPTY, 8'd0, op_q, 1'b1, RSN_PEER);
              n = 2'd1;
            end else if (op_q == OP_CLOSE) begin
              r0 = mk_res(KIND_DISC, 8'd0, 4'd0, 1'b0, RSN_PEER);
              n = 2'd1;
              closed_d = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          if (is_data_op(op_q)) begin
            r0 = mk_res(KIND_DATA, pdata, op_q, last, RSN_PEER);
            n = 2'd1;
          end else if (op_q == OP_PING) begin
            r0 = mk_res(KIND_TX, pdata, 4'd0, last, RSN_PEER);
            n = 2'd1;
          end else if (op_q == OP_CLOSE) begin
            // echo only the 2-byte status code
            if (pos_q < LENGTH_BITS'(2) && len_q >= LENGTH_BITS'(2)) begin
              r0 = mk_res(KIND_TX, pdata, 4'd0, pos_q == LENGTH_BITS'(1), RSN_PEER);
              n = 2'd1;
            end
            if (last) begin
              if (n == 2'd1) begin
                r1 = mk_res(KIND_DISC, 8'd0, 4'd0, 1'b0, RSN_PEER);
                n = 2'd2;
              end else begin
                r0 = mk_res(KIND_DISC, 8'd0, 4'd0, 1'b0, RSN_PEER);
                n = 2'd1;
              end
              closed_d = 1'b1;
            end
          end
          pos_d = pos_p1[LENGTH_BITS-1:0];
          if (last) begin
            pos_d   = '0;
            phase_d = PH_HDR0;
          end
        end
        default: phase_d = PH_HDR0;
      endcase
    end

    if (n == 2'd1) r0.run_last = 1'b1;
    if (n == 2'd2) r1.run_last = 1'b1;

    push_o.cnt = in_fire_i ? n : 2'd0;
    push_o.r0  = r0;
    push_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      op_q     <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      mask_q   <= '{default: 8'd0};
      closed_q <= 1'b0;
    end else if (in_fire_i) begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      mask_q   <= mask_d;
      closed_q <= closed_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wsfr_outq.sv
// wsfr_outq: small result queue between the decoder and the output channel.
// Takes up to two results per cycle, hands out one per beat. Depends on wsfr_pkg.
`default_nettype none

module wsfr_outq (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire wsfr_pkg::push_t  push_i,
  input  wire                   out_stall_i,
  output logic                  out_valid_o,
  output wsfr_pkg::res_t        head_o,
  output logic                  busy_o
);
  import wsfr_pkg::*;

  res_t                ent_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_q, rd_q;
  logic [OQ_CNT_W-1:0] cnt_q;
  logic                pop;
  logic [OQ_PTR_W-1:0] wr_p1;

  assign out_valid_o = cnt_q != '0;
  assign head_o      = ent_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_p1       = wr_q + OQ_PTR_W'(1);
  // room must remain for the worst case of two results from one byte
  assign busy_o      = cnt_q > OQ_CNT_W'(OQ_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) ent_q[wr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) ent_q[wr_p1] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OQ_PTR_W'(push_i.cnt);
      if (pop) rd_q <= rd_q + OQ_PTR_W'(1);
      cnt_q <= cnt_q + OQ_CNT_W'(push_i.cnt) - OQ_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

>>> rtl/websocket_frame_receiver_core.sv
// websocket_frame_receiver_core: top level of the client-to-server frame receiver.
// Instantiates wsfr_decode and wsfr_outq; depends on wsfr_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   in      | input     | in_valid_i/in_stall_o   | rx_byte_i
//   out     | output    | out_valid_o/out_stall_i | kind_o data_byte_o frame_opcode_o
//           |           |                     | frame_end_o end_reason_o run_last_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (max_payload)
//
// One received byte per cycle. Frame state updates on the accepting edge and
// its results land in a 4-entry result queue, first visible the next cycle.
// Bytes that make two results (pong/close header, close status end) cost one
// extra output beat; the queue depth sets how far the input runs ahead.
// Reset: link open, header expected, max_payload = 204, queue empty.
// An output stall holds the head beat; input stalls once the queue can no
// longer take two more results. cfg_ready_o is always high.
`default_nettype none

module websocket_frame_receiver_core #(
  parameter int LENGTH_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // byte input
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  rx_byte_i,
  // result output
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [3:0]  frame_opcode_o,
  output logic        frame_end_o,
  output logic [1:0]  end_reason_o,
  output logic        run_last_o,
  // max_payload register write
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [15:0] cfg_data_i
);
  import wsfr_pkg::*;

  logic        in_fire;
  logic        busy;
  logic [15:0] max_payload_q;
  push_t       push;
  res_t        head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign in_fire     = in_valid_i && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_payload_q <= cfg_data_i;
    end
  end

  wsfr_decode #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_fire_i     (in_fire),
    .rx_byte_i     (rx_byte_i),
    .max_payload_i (max_payload_q),
    .push_o        (push)
  );

  wsfr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .busy_o      (busy)
  );

  assign kind_o         = head.kind;
  assign data_byte_o    = head.data;
  assign frame_opcode_o = head.opcode;
  assign frame_end_o    = head.frame_end;
  assign end_reason_o   = head.reason;
  assign run_last_o     = head.run_last;

endmodule

`default_nettype wire

>>> rtl/wsfr_checker.sv
// wsfr_checker: port-level assertions for websocket_frame_receiver_core.
// Bound to the top level below; depends on wsfr_pkg for result codes.
`default_nettype none

module wsfr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  kind_o,
  input wire [7:0]  data_byte_o,
  input wire [3:0]  frame_opcode_o,
  input wire        frame_end_o,
  input wire [1:0]  end_reason_o,
  input wire        run_last_o
);
  import wsfr_pkg::*;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
    $stable(data_byte_o) && $stable(frame_end_o) && $stable(run_last_o))
    else $error("stalled output beat changed");

  // a disconnect is always the final result of its byte
  a_disc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DISC |-> run_last_o && !frame_end_o &&
    data_byte_o == 8'd0 && frame_opcode_o == 4'd0)
    else $error("disconnect beat malformed");

  // empty data frame carries a data opcode and closes the frame
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_EMPTY |-> frame_end_o && run_last_o &&
    (frame_opcode_o == OP_TEXT || frame_opcode_o == OP_BINARY))
    else $error("empty frame beat malformed");

  // only disconnects carry a reason
  a_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_DISC |-> end_reason_o == RSN_PEER)
    else $error("reason on non-disconnect beat");

endmodule

bind websocket_frame_receiver_core wsfr_checker u_wsfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .data_byte_o    (data_byte_o),
  .frame_opcode_o (frame_opcode_o),
  .frame_end_o    (frame_end_o),
  .end_reason_o   (end_reason_o),
  .run_last_o     (run_last_o)
);

`default_nettype wire
